// ----- sv/assert_macros.svh -----
// ============================================================================
// Assertion macros
// Shared concurrent assertion wrappers for the swap engine checkers.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define CPSE_ASSERT(name, clk, rstn, prop) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) prop) \
        else $error("cpse assertion failed");

// expression must never be true outside reset
`define CPSE_ASSERT_NEVER(name, clk, rstn, expr) \
    `CPSE_ASSERT(name, clk, rstn, !(expr))

`endif

// ----- sv/cpse_pkg.sv -----
// ============================================================================
// cpse_pkg
// Types and constants of the collision penalty swap engine.
// ============================================================================
`timescale 1ns / 1ps

package cpse_pkg;

    localparam int GROUP_W        = 10;
    localparam int COUNT_W        = 10;
    localparam int COUNT_MAX      = 1023;
    localparam int TOTAL_W        = 20;
    localparam int TOTAL_MAX      = 1048575;
    localparam int DELTA_W        = 14;
    localparam int DELTA_LIM      = 4096;
    localparam int NET_W          = 4;
    localparam int ROW_LEN        = 4;
    localparam int SLOTS          = 2 * ROW_LEN;
    localparam int NUM_GROUPS_DEF = 1024;

    typedef enum logic [1:0] {
        OP_EVAL  = 2'd0,
        OP_APPLY = 2'd1,
        OP_ADD   = 2'd2,
        OP_CLEAR = 2'd3
    } t_op;

    // one distinct group of a request with its net count change
    typedef struct packed {
        logic                    live;
        logic [GROUP_W-1:0]      id;
        logic signed [NET_W-1:0] net;
    } t_slot;

    // result of one pass through the update unit
    typedef struct packed {
        logic [COUNT_W-1:0] next;
        logic [DELTA_W-1:0] term;
        logic               sat;
    } t_unit_res;

endpackage

// ----- sv/cpse_prep.sv -----
// ============================================================================
// cpse_prep
// Merges the eight group slots of a request into distinct groups with nets.
// ============================================================================
`timescale 1ns / 1ps

module cpse_prep #(
    parameter int NUM_GROUPS = cpse_pkg::NUM_GROUPS_DEF
) (
    input  logic [1:0]                   i_operation,
    input  logic [cpse_pkg::GROUP_W-1:0] i_groups [cpse_pkg::SLOTS],
    output cpse_pkg::t_slot              o_slots  [cpse_pkg::SLOTS]
);
    import cpse_pkg::*;

    localparam int AW    = $clog2(NUM_GROUPS);
    localparam int CMP_W = GROUP_W + AW;

    logic [SLOTS-1:0] w_present;

    always_comb begin
        for (int k = 0; k < SLOTS; k++) begin
            w_present[k] = (CMP_W'(i_groups[k]) < CMP_W'(NUM_GROUPS)) &&
                           ((k >= ROW_LEN) || (t_op'(i_operation) != OP_ADD));
        end
    end

    always_comb begin
        logic                    first;
        logic signed [NET_W-1:0] net;
        for (int k = 0; k < SLOTS; k++) begin
            first = w_present[k];
            net   = '0;
            for (int j = 0; j < SLOTS; j++) begin
                if (w_present[j] && (i_groups[j] == i_groups[k])) begin
                    if (j < ROW_LEN) begin
                        net = net - NET_W'(1);
                    end else begin
                        net = net + NET_W'(1);
                    end
                    if (j < k) begin
                        first = 1'b0;
                    end
                end
            end
            o_slots[k].live = first && (net != '0);
            o_slots[k].id   = i_groups[k];
            o_slots[k].net  = net;
        end
    end

endmodule

// ----- sv/cpse_unit.sv -----
// ============================================================================
// cpse_unit
// Shared count update unit: clamps count plus net, returns pair-count change.
// ============================================================================
`timescale 1ns / 1ps

module cpse_unit (
    input  logic [cpse_pkg::COUNT_W-1:0]    i_count,
    input  logic signed [cpse_pkg::NET_W-1:0] i_net,
    output cpse_pkg::t_unit_res             o_res
);
    import cpse_pkg::*;

    localparam int SUM_W = COUNT_W + 2;
    localparam logic signed [SUM_W-1:0] C_MAX = SUM_W'(COUNT_MAX);
    localparam logic signed [SUM_W-1:0] C_ONE = SUM_W'(1);

    always_comb begin
        logic signed [SUM_W-1:0]   c_s;
        logic signed [SUM_W-1:0]   t;
        logic signed [SUM_W-1:0]   d;
        logic signed [SUM_W-1:0]   s;
        logic signed [2*SUM_W-1:0] prod;
        logic                      sat;
        c_s = $signed({2'b00, i_count});
        t   = c_s + SUM_W'(i_net);
        sat = 1'b0;
        if (t > C_MAX) begin
            t   = C_MAX;
            sat = 1'b1;
        end else if (t < $signed(SUM_W'(0))) begin
            t   = '0;
            sat = 1'b1;
        end
        // P(t) - P(c) = (t - c) * (t + c - 1) / 2, product always even
        d    = t - c_s;
        s    = t + c_s - C_ONE;
        prod = d * s;
        o_res.next = t[COUNT_W-1:0];
        o_res.term = DELTA_W'(prod >>> 1);
        o_res.sat  = sat;
    end

endmodule

// ----- sv/collision_penalty_swap_engine_top.sv -----
// ============================================================================
// collision_penalty_swap_engine_top
// Group occupancy store with running collision penalty and swap evaluation.
// ============================================================================
// channel   direction  handshake                 payload
// in        input      i_in_valid / o_in_stall   i_operation, i_old_group_*, i_new_group_*
// out       output     o_out_valid / i_out_stall o_penalty_delta, o_total_penalty, o_saturated
//
// Evaluate, apply and add step through the eight group slots in turn: each slot
// has a read state and an update state on the count memory.
// Clear zeroes one memory entry per cycle.
// After reset a clearing pass over all NUM_GROUPS entries runs with o_in_stall high.
// A finished result waits in the output register; the next request is taken
// meanwhile, and a second result waits only until the first is taken.
// ============================================================================
`timescale 1ns / 1ps

module collision_penalty_swap_engine_top #(
    parameter int NUM_GROUPS = cpse_pkg::NUM_GROUPS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [1:0]                         i_operation,
    input  logic [cpse_pkg::GROUP_W-1:0]       i_old_group_0,
    input  logic [cpse_pkg::GROUP_W-1:0]       i_old_group_1,
    input  logic [cpse_pkg::GROUP_W-1:0]       i_old_group_2,
    input  logic [cpse_pkg::GROUP_W-1:0]       i_old_group_3,
    input  logic [cpse_pkg::GROUP_W-1:0]       i_new_group_0,
    input  logic [cpse_pkg::GROUP_W-1:0]       i_new_group_1,
    input  logic [cpse_pkg::GROUP_W-1:0]       i_new_group_2,
    input  logic [cpse_pkg::GROUP_W-1:0]       i_new_group_3,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic signed [cpse_pkg::DELTA_W-1:0] o_penalty_delta,
    output logic [cpse_pkg::TOTAL_W-1:0]       o_total_penalty,
    output logic                               o_saturated
);
    import cpse_pkg::*;

    localparam int AW    = $clog2(NUM_GROUPS);
    localparam int IDX_W = $clog2(SLOTS);
    localparam int TOT_X = TOTAL_W + 2;

    typedef enum logic [2:0] {
        S_CLR,
        S_IDLE,
        S_RD,
        S_UP,
        S_TOT
    } t_state;

    t_state                    r_state;
    t_op                       r_op;
    t_slot                     r_slots [SLOTS];
    logic [IDX_W-1:0]          r_idx;
    logic [AW-1:0]             r_clr;
    logic                      r_clr_op;
    logic signed [DELTA_W-1:0] r_delta;
    logic                      r_sat;
    logic [TOTAL_W-1:0]        r_total;
    logic [COUNT_W-1:0]        r_rd_data;
    logic [COUNT_W-1:0]        r_mem [NUM_GROUPS];
    logic                      r_out_valid;
    logic signed [DELTA_W-1:0] r_out_delta;
    logic [TOTAL_W-1:0]        r_out_total;
    logic                      r_out_sat;

    logic [GROUP_W-1:0]        w_groups [SLOTS];
    t_slot                     w_slots  [SLOTS];
    t_slot                     w_cur;
    t_unit_res                 w_res;
    logic signed [DELTA_W-1:0] w_term;
    logic [GROUP_W+AW-1:0]     w_wide;
    logic [AW-1:0]             w_slot_addr;
    logic                      w_commit;
    logic                      w_mem_we;
    logic [AW-1:0]             w_mem_wa;
    logic [COUNT_W-1:0]        w_mem_wd;
    logic signed [TOT_X-1:0]   w_tot;
    logic [TOTAL_W-1:0]        n_total;
    logic                      n_tot_sat;
    logic                      w_out_free;

    assign w_groups[0] = i_old_group_0;
    assign w_groups[1] = i_old_group_1;
    assign w_groups[2] = i_old_group_2;
    assign w_groups[3] = i_old_group_3;
    assign w_groups[4] = i_new_group_0;
    assign w_groups[5] = i_new_group_1;
    assign w_groups[6] = i_new_group_2;
    assign w_groups[7] = i_new_group_3;

    cpse_prep #(
        .NUM_GROUPS (NUM_GROUPS)
    ) u_prep (
        .i_operation (i_operation),
        .i_groups    (w_groups),
        .o_slots     (w_slots)
    );

    assign w_cur       = r_slots[r_idx];
    assign w_wide      = (GROUP_W + AW)'(w_cur.id);
    assign w_slot_addr = w_wide[AW-1:0];

    cpse_unit u_unit (
        .i_count (r_rd_data),
        .i_net   (w_cur.net),
        .o_res   (w_res)
    );

    assign w_term   = $signed(w_res.term);
    assign w_commit = (r_op != OP_EVAL);
    assign w_mem_we = (r_state == S_CLR) ||
                      ((r_state == S_UP) && w_cur.live && w_commit);
    assign w_mem_wa = (r_state == S_CLR) ? r_clr : w_slot_addr;
    assign w_mem_wd = (r_state == S_CLR) ? '0 : w_res.next;

    always_comb begin
        w_tot     = $signed({2'b00, r_total}) + TOT_X'(r_delta);
        n_tot_sat = 1'b0;
        if (w_tot > $signed(TOT_X'(TOTAL_MAX))) begin
            n_total   = TOTAL_W'(TOTAL_MAX);
            n_tot_sat = 1'b1;
        end else if (w_tot < $signed(TOT_X'(0))) begin
            n_total   = '0;
            n_tot_sat = 1'b1;
        end else begin
            n_total = w_tot[TOTAL_W-1:0];
        end
    end

    assign w_out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_mem_wa] <= w_mem_wd;
        end
        r_rd_data <= r_mem[w_slot_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr       <= '0;
            r_clr_op    <= 1'b0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall && (r_state != S_TOT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLR: begin
                    if (r_clr == AW'(NUM_GROUPS - 1)) begin
                        r_clr <= '0;
                        if (r_clr_op) begin
                            r_clr_op <= 1'b0;
                            r_total  <= '0;
                            r_delta  <= '0;
                            r_sat    <= 1'b0;
                            r_state  <= S_TOT;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end else begin
                        r_clr <= r_clr + AW'(1);
                    end
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_op    <= t_op'(i_operation);
                        r_slots <= w_slots;
                        r_idx   <= '0;
                        r_delta <= '0;
                        r_sat   <= 1'b0;
                        if (t_op'(i_operation) == OP_CLEAR) begin
                            r_clr_op <= 1'b1;
                            r_clr    <= '0;
                            r_state  <= S_CLR;
                        end else begin
                            r_state <= S_RD;
                        end
                    end
                end
                S_RD: begin
                    r_state <= S_UP;
                end
                S_UP: begin
                    if (w_cur.live) begin
                        r_delta <= r_delta + w_term;
                        r_sat   <= r_sat | w_res.sat;
                    end
                    if (r_idx == IDX_W'(SLOTS - 1)) begin
                        r_state <= S_TOT;
                    end else begin
                        r_idx   <= r_idx + IDX_W'(1);
                        r_state <= S_RD;
                    end
                end
                S_TOT: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_delta <= r_delta;
                        r_out_sat   <= r_sat | (w_commit & n_tot_sat);
                        r_out_total <= w_commit ? n_total : r_total;
                        if (w_commit) begin
                            r_total <= n_total;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall      = (r_state != S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_penalty_delta = r_out_delta;
    assign o_total_penalty = r_out_total;
    assign o_saturated     = r_out_sat;

endmodule

// ----- sv/cpse_checker.sv -----
// ============================================================================
// cpse_checker
// Port-level checks of the swap engine, bound to the top level.
// ============================================================================
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cpse_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_in_valid,
    input logic                                o_in_stall,
    input logic                                o_out_valid,
    input logic                                i_out_stall,
    input logic signed [cpse_pkg::DELTA_W-1:0] o_penalty_delta,
    input logic [cpse_pkg::TOTAL_W-1:0]        o_total_penalty,
    input logic                                o_saturated
);
    import cpse_pkg::*;

    localparam logic signed [DELTA_W-1:0] D_LIM = DELTA_W'(DELTA_LIM);

    logic       w_in_acc;
    logic       w_out_acc;
    logic [1:0] r_cnt;

    assign w_in_acc  = i_in_valid && !o_in_stall;
    assign w_out_acc = o_out_valid && !i_out_stall;

    // requests taken but not yet answered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (w_in_acc && !w_out_acc) begin
            r_cnt <= r_cnt + 2'd1;
        end else if (w_out_acc && !w_in_acc) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    `CPSE_ASSERT(a_out_hold, i_clk, i_rst_n, (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_penalty_delta) && $stable(o_total_penalty) && $stable(o_saturated)))
    `CPSE_ASSERT(a_busy_after_accept, i_clk, i_rst_n, w_in_acc |=> o_in_stall)
    `CPSE_ASSERT_NEVER(a_no_orphan_result, i_clk, i_rst_n, o_out_valid && (r_cnt == 2'd0))
    `CPSE_ASSERT_NEVER(a_backlog_limit, i_clk, i_rst_n, r_cnt == 2'd3)
    `CPSE_ASSERT(a_delta_range, i_clk, i_rst_n, o_out_valid |-> ((o_penalty_delta >= -D_LIM) && (o_penalty_delta <= D_LIM)))

endmodule

bind collision_penalty_swap_engine_top cpse_checker u_cpse_checker (.*);

// ----- bench/collision_penalty_swap_engine_top_tb.sv -----
// ============================================================================
// collision_penalty_swap_engine_top_tb
// Self-checking bench for the collision penalty swap engine.
// ============================================================================
// A scoreboard keeps its own copy of the group counts and the running penalty.
// It predicts delta, total and saturation for every accepted request and
// checks each result against the oldest prediction.
// Stimulus runs in three parts:
// - Directed requests cover every operation, repeated groups, extreme group
//   numbers and the removal of rows that were never added.
// - Random requests are mostly well-formed swaps of rows already placed.
// - A stress sequence drives counts to their limit and the penalty past its
//   top.
// Both sides idle at random. One long receiver hold-off backs the block up.
// ============================================================================
`timescale 1ns / 1ps

module collision_penalty_swap_engine_top_tb;
    import cpse_pkg::*;

    localparam int TABLE_SIZE   = NUM_GROUPS_DEF;
    localparam int RANDOM_ITEMS = 250;
    localparam int HOLD_CYCLES  = 300;
    localparam int FILL_CAP     = 1000;
    localparam int END_CYCLES   = 40;
    localparam int GROUP_A      = 100;
    localparam int GROUP_B      = 200;
    localparam int GROUP_C      = 300;

    typedef logic [ROW_LEN-1:0][GROUP_W-1:0] t_row;

    typedef struct packed {
        logic signed [DELTA_W-1:0] delta;
        logic [TOTAL_W-1:0]        total;
        logic                      sat;
    } t_penalty_result;

    class penalty_scoreboard;
        logic [COUNT_W-1:0] counts [TABLE_SIZE];
        logic [TOTAL_W-1:0] total;
        t_penalty_result    awaited [$];
        int unsigned        requests, results, errors, clears;
        int unsigned        sat_results, high_clamps, low_clamps;

        function new();
            foreach (counts[i]) counts[i] = '0;
            total = '0;
        endfunction

        function int pairs(int n);
            return (n * (n - 1)) / 2;
        endfunction

        function void flag_mismatch(string field, logic signed [31:0] want_v,
                                    logic signed [31:0] got_v);
            errors++;
            $display("%0t: %s expected %0d actual %0d", $time, field, want_v, got_v);
        endfunction

        function void note_request(t_op op, t_row olds, t_row news);
            int              ids [SLOTS];
            int              net [SLOTS];
            int              nxt [SLOTS];
            int              used, delta, g, dir, c, t, j, k;
            bit              sat;
            longint          tot;
            t_penalty_result res;
            requests++;
            if (op == OP_CLEAR) begin
                foreach (counts[i]) counts[i] = '0;
                total = '0;
                clears++;
                res = '0;
                awaited.insert(awaited.size(), res);
                return;
            end
            used  = 0;
            delta = 0;
            sat   = 1'b0;
            for (k = 0; k < SLOTS; k++) begin
                if (k < ROW_LEN) begin
                    if (op == OP_ADD)
                        continue;
                    g   = olds[k];
                    dir = -1;
                end else begin
                    g   = news[k - ROW_LEN];
                    dir = 1;
                end
                if (g >= TABLE_SIZE)
                    continue;
                for (j = 0; j < used; j++)
                    if (ids[j] == g)
                        break;
                if (j == used) begin
                    ids[used] = g;
                    net[used] = 0;
                    used++;
                end
                net[j] += dir;
            end
            for (j = 0; j < used; j++) begin
                c      = counts[ids[j]];
                t      = c + net[j];
                nxt[j] = c;
                if (net[j] != 0) begin
                    if (t > COUNT_MAX) begin
                        t   = COUNT_MAX;
                        sat = 1'b1;
                    end
                    if (t < 0) begin
                        t   = 0;
                        sat = 1'b1;
                    end
                    nxt[j] = t;
                    delta += pairs(t) - pairs(c);
                end
            end
            if (op != OP_EVAL) begin
                tot = longint'(total) + delta;
                for (j = 0; j < used; j++)
                    counts[ids[j]] = COUNT_W'(nxt[j]);
                if (tot > TOTAL_MAX) begin
                    tot = TOTAL_MAX;
                    sat = 1'b1;
                    high_clamps++;
                end
                if (tot < 0) begin
                    tot = 0;
                    sat = 1'b1;
                    low_clamps++;
                end
                total = TOTAL_W'(tot);
            end
            if (sat)
                sat_results++;
            res.delta = DELTA_W'(delta);
            res.total = total;
            res.sat   = sat;
            awaited.insert(awaited.size(), res);
        endfunction

        function void check_result(logic signed [DELTA_W-1:0] delta,
                                   logic [TOTAL_W-1:0] tot, logic sat);
            t_penalty_result want;
            results++;
            if (awaited.size() == 0) begin
                errors++;
                $display("%0t: result with no request pending, delta %0d total %0d",
                         $time, delta, tot);
                return;
            end
            want = awaited.pop_front();
            if (delta !== want.delta)
                flag_mismatch("penalty_delta", want.delta, delta);
            if (tot !== want.total)
                flag_mismatch("total_penalty", want.total, tot);
            if (sat !== want.sat)
                flag_mismatch("saturated", want.sat, sat);
        endfunction
    endclass

    logic                        i_clk = 1'b0;
    logic                        i_rst_n;
    logic                        i_in_valid;
    logic                        o_in_stall;
    logic [1:0]                  i_operation;
    logic [GROUP_W-1:0]          i_old_group_0, i_old_group_1, i_old_group_2, i_old_group_3;
    logic [GROUP_W-1:0]          i_new_group_0, i_new_group_1, i_new_group_2, i_new_group_3;
    logic                        o_out_valid;
    logic                        i_out_stall;
    logic signed [DELTA_W-1:0]   o_penalty_delta;
    logic [TOTAL_W-1:0]          o_total_penalty;
    logic                        o_saturated;

    bit no_idle    = 1'b0;
    bit start_hold = 1'b0;
    bit hold_off   = 1'b0;

    penalty_scoreboard sb = new();

    collision_penalty_swap_engine_top #(
        .NUM_GROUPS(TABLE_SIZE)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_operation     (i_operation),
        .i_old_group_0   (i_old_group_0),
        .i_old_group_1   (i_old_group_1),
        .i_old_group_2   (i_old_group_2),
        .i_old_group_3   (i_old_group_3),
        .i_new_group_0   (i_new_group_0),
        .i_new_group_1   (i_new_group_1),
        .i_new_group_2   (i_new_group_2),
        .i_new_group_3   (i_new_group_3),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_penalty_delta (o_penalty_delta),
        .o_total_penalty (o_total_penalty),
        .o_saturated     (o_saturated)
    );

    always #1 i_clk = ~i_clk;

    function automatic t_row row(int a, int b, int c, int d);
        t_row r;
        r[0] = GROUP_W'(a);
        r[1] = GROUP_W'(b);
        r[2] = GROUP_W'(c);
        r[3] = GROUP_W'(d);
        return r;
    endfunction

    // mostly a small working set so that groups collide
    function automatic t_row random_row();
        t_row r;
        int   k, m;
        for (k = 0; k < ROW_LEN; k++) begin
            m = $urandom_range(0, 9);
            if (m < 7)
                r[k] = GROUP_W'($urandom_range(0, 15));
            else if (m == 7 && k > 0)
                r[k] = r[k - 1];
            else if (m == 8)
                r[k] = $urandom_range(0, 1) ? {GROUP_W{1'b1}} : {GROUP_W{1'b0}};
            else
                r[k] = GROUP_W'($urandom_range(0, TABLE_SIZE - 1));
        end
        return r;
    endfunction

    task automatic send_request(input t_op op, input t_row olds, input t_row news);
        int r, gap;
        i_in_valid    <= 1'b1;
        i_operation   <= op;
        i_old_group_0 <= olds[0];
        i_old_group_1 <= olds[1];
        i_old_group_2 <= olds[2];
        i_old_group_3 <= olds[3];
        i_new_group_0 <= news[0];
        i_new_group_1 <= news[1];
        i_new_group_2 <= news[2];
        i_new_group_3 <= news[3];
        do
            @(posedge i_clk);
        while (o_in_stall);
        sb.note_request(op, olds, news);
        r = $urandom_range(0, 99);
        if (no_idle || r < 55)
            gap = 0;
        else if (r < 93)
            gap = $urandom_range(1, 4);
        else
            gap = $urandom_range(15, 50);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    initial begin
        int stall_left;
        stall_left = 0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid && !i_out_stall)
                sb.check_result(o_penalty_delta, o_total_penalty, o_saturated);
            if (stall_left > 0)
                stall_left--;
            else if (!no_idle && $urandom_range(0, 99) < 30)
                stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 50)
                                                          : $urandom_range(1, 3);
            i_out_stall <= hold_off || (stall_left > 0);
        end
    end

    initial begin
        wait (start_hold);
        @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    initial begin
        #2_800_000;
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        t_op  op;
        t_row olds, news;
        t_row placed [$];
        int   n, idx, r, pick;

        i_rst_n       <= 1'b0;
        i_in_valid    <= 1'b0;
        i_operation   <= OP_EVAL;
        i_old_group_0 <= '0;
        i_old_group_1 <= '0;
        i_old_group_2 <= '0;
        i_old_group_3 <= '0;
        i_new_group_0 <= '0;
        i_new_group_1 <= '0;
        i_new_group_2 <= '0;
        i_new_group_3 <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_request(OP_EVAL,  row(0, 0, 0, 0), row(1023, 1023, 1023, 1023));
        send_request(OP_ADD,   row(0, 0, 0, 0), row(1023, 1023, 1023, 1023));
        send_request(OP_ADD,   row(1023, 1023, 1023, 1023), row(0, 0, 0, 0));
        send_request(OP_ADD,   row(5, 6, 7, 8), row(1, 2, 3, 4));
        send_request(OP_ADD,   row(0, 0, 0, 0), row(1, 1, 2, 2));
        send_request(OP_EVAL,  row(1023, 1023, 1023, 1023), row(0, 0, 0, 0));
        send_request(OP_APPLY, row(1023, 1023, 1023, 1023), row(0, 0, 0, 0));
        send_request(OP_APPLY, row(1, 2, 3, 4), row(4, 3, 2, 1));
        send_request(OP_APPLY, row(500, 501, 502, 503), row(600, 601, 602, 603));
        send_request(OP_EVAL,  row(0, 0, 1, 2), row(0, 1, 1, 3));
        send_request(OP_APPLY, row(0, 0, 1, 2), row(0, 1, 1, 3));
        send_request(OP_EVAL,  row('h155, 'h2AA, 'h155, 'h2AA), row('h2AA, 'h155, 'h3FF, 0));
        send_request(OP_ADD,   row('h3FF, 'h3FF, 'h3FF, 'h3FF), row(5, 5, 5, 6));
        send_request(OP_APPLY, row(5, 5, 5, 5), row(6, 6, 6, 6));
        send_request(OP_CLEAR, row('h3FF, 'h155, 'h2AA, 1), row('h2AA, 'h155, 'h3FF, 2));
        send_request(OP_EVAL,  row(1, 2, 3, 4), row(5, 6, 7, 8));
        send_request(OP_APPLY, row(0, 0, 0, 0), row(9, 9, 10, 10));
        send_request(OP_ADD,   row(0, 0, 0, 0), row(9, 10, 9, 10));
        send_request(OP_APPLY, row(9, 9, 9, 9), row(1023, 0, 1023, 0));
        send_request(OP_CLEAR, row(0, 0, 0, 0), row(0, 0, 0, 0));

        for (n = 0; n < RANDOM_ITEMS; n++) begin
            no_idle = (n >= 50 && n < 100);
            if (n == 150)
                start_hold = 1'b1;
            r    = $urandom_range(0, 99);
            news = random_row();
            olds = random_row();
            if (r < 2)
                op = OP_CLEAR;
            else if (r < 27 && placed.size() < 48)
                op = OP_ADD;
            else if (r < 60)
                op = OP_EVAL;
            else
                op = OP_APPLY;
            if (op == OP_CLEAR) begin
                placed.delete();
            end else if (op == OP_ADD) begin
                placed.insert(placed.size(), news);
            end else if (placed.size() > 0 && $urandom_range(0, 9) < 8) begin
                idx  = $urandom_range(0, placed.size() - 1);
                olds = placed[idx];
                if (op == OP_APPLY)
                    placed[idx] = news;
            end
            send_request(op, olds, news);
        end
        no_idle = 1'b0;

        // push two groups to the count limit and a third until the penalty tops out
        n = 0;
        while ((sb.counts[GROUP_A] != COUNT_MAX || sb.counts[GROUP_B] != COUNT_MAX ||
                sb.high_clamps == 0) && n < FILL_CAP) begin
            if (sb.counts[GROUP_A] != COUNT_MAX)
                pick = GROUP_A;
            else if (sb.counts[GROUP_B] != COUNT_MAX)
                pick = GROUP_B;
            else
                pick = GROUP_C;
            send_request(OP_ADD, random_row(), row(pick, pick, pick, pick));
            n++;
        end

        send_request(OP_EVAL, row(GROUP_C, 0, 1, 2), row(3, 4, 5, 6));
        send_request(OP_CLEAR, random_row(), random_row());
        i_in_valid <= 1'b0;

        while (sb.awaited.size() != 0)
            @(posedge i_clk);
        repeat (END_CYCLES) @(posedge i_clk);

        $display("Sent %0d requests (%0d clears), checked %0d results",
                 sb.requests, sb.clears, sb.results);
        $display("Saturated results %0d, penalty held at top %0d times, at zero %0d times",
                 sb.sat_results, sb.high_clamps, sb.low_clamps);
        if (sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
